@@ rtl/ppi_pkg.sv @@
package ppi_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_W         = 64;
    localparam int IDX_W         = 3;
    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    localparam logic [IDX_W-1:0] REG_SPAWN = 3'd0;
    localparam logic [IDX_W-1:0] REG_LIFE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SIZE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_VX    = 3'd3;
    localparam logic [IDX_W-1:0] REG_VY    = 3'd4;
    localparam logic [IDX_W-1:0] REG_GRAV  = 3'd5;
    localparam logic [IDX_W-1:0] REG_SEED  = 3'd6;

    localparam logic CMD_EMIT = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_PART  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_DRAW,
        ST_DRAW_WB,
        ST_EMIT_OUT,
        ST_RD,
        ST_LIFE,
        ST_VEL,
        ST_VEL_WB,
        ST_POS,
        ST_POS_WB,
        ST_TICK_OUT,
        ST_NEXT,
        ST_WAIT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sd2147483647) begin
                r = 32'sh7FFF_FFFF;
            end else if (v < -66'sd2147483648) begin
                r = 32'sh8000_0000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/particle_pool_integrator_core.sv @@
// Particle pool integrator.
// Input words on s_axis: tdata carries delta_time, tuser carries the command
// (0 emit, 1 tick). Result words on m_axis: tdata packs slot, pos_x, pos_y and
// particle_size from the low bits up, tuser carries kind, and tlast marks the final
// word of a command. Configuration goes through a plain write port (index, 64-bit
// data). The user must write it only while the block is idle; the block itself
// does not enforce this. An emit takes the free slot from a priority pick over
// the active bits, then makes four random draws in turn, each a draw state and a
// write-back state on the shared 33x33 multiplier, before the result word becomes
// valid. A tick visits every slot in order. An inactive slot is skipped, a slot
// that retires is cleared from the active bits, and a surviving slot has its two
// velocity products and two position products made in turn, since they share the
// multiplier and the saturating adder.
// Each survivor is held back until the next one is found, so that tlast can be set
// on the final word. The block takes no new word until every result of the current
// one has been taken; a stalled receiver holds the sequencer where it waits.
// Reset clears the active bits, the configuration registers to zero and the random
// generator to one; slot memories need no clearing.
module particle_pool_integrator_core #(
    parameter int POOL_SIZE = ppi_pkg::POOL_SIZE_DEF,
    parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,  // delta_time
    input  logic                    s_axis_tuser,  // command
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // slot [5:0], pos_x [37:6], pos_y [69:38], size [101:70], zero fill
    output logic [103:0]            m_axis_tdata,
    output logic [1:0]              m_axis_tuser,  // kind
    output logic                    m_axis_tlast,
    input  logic                    i_cfg_we,
    input  logic [ppi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [ppi_pkg::REG_W-1:0] i_cfg_data
);
    import ppi_pkg::*;

    localparam int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    logic [63:0] r_spawn, r_life, r_size, r_vx, r_vy, r_grav;
    logic [31:0] r_lfsr, n_lfsr;

    logic [31:0] m_px [POOL_SIZE];
    logic [31:0] m_py [POOL_SIZE];
    logic [31:0] m_vx [POOL_SIZE];
    logic [31:0] m_vy [POOL_SIZE];
    logic [31:0] m_lf [POOL_SIZE];
    logic [31:0] m_sz [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_active, n_active;

    t_state r_st, n_st;
    logic [SW-1:0] r_slot, n_slot;
    logic [1:0] r_sub, n_sub;          // draw or axis counter
    logic [31:0] r_dt, n_dt;
    logic r_any, n_any;                // a survivor word is held back
    logic [103:0] r_pdata, n_pdata;    // the held survivor word
    logic signed [31:0] r_a [4];       // px, py, vx, vy in both emit and tick
    logic signed [31:0] n_a [4];
    logic signed [31:0] r_life_v, n_life_v;
    logic [31:0] r_sz_v, n_sz_v;
    logic signed [65:0] r_prod, n_prod;
    logic [1:0] r_okind, n_okind;
    logic r_olast, n_olast;
    logic r_ovalid, n_ovalid;
    logic [103:0] r_odata, n_odata;
    logic r_we, n_we;

    // Read data registered from slot memories.
    logic [31:0] q_px, q_py, q_vx, q_vy, q_lf, q_sz;

    // Shared multiplier operands.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = 66'(mul_a * mul_b);

    // First free slot.
    logic          free_ok;
    logic [SW-1:0] free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_ok  = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        q_px <= m_px[r_slot];
        q_py <= m_py[r_slot];
        q_vx <= m_vx[r_slot];
        q_vy <= m_vy[r_slot];
        q_lf <= m_lf[r_slot];
        q_sz <= m_sz[r_slot];
        if (r_we) begin
            m_px[r_slot] <= r_a[0];
            m_py[r_slot] <= r_a[1];
            m_vx[r_slot] <= r_a[2];
            m_vy[r_slot] <= r_a[3];
            m_lf[r_slot] <= r_life_v;
            m_sz[r_slot] <= r_sz_v;
        end
    end

    // Range selection for draw r_sub.
    logic [63:0] rng;
    logic        rng_uns;
    logic signed [32:0] lo33, hi33;
    always_comb begin
        case (r_sub)
            2'd0:    rng = r_life;
            2'd1:    rng = r_size;
            2'd2:    rng = r_vx;
            default: rng = r_vy;
        endcase
        rng_uns = (r_sub == 2'd1);
        lo33 = rng_uns ? $signed({1'b0, rng[31:0]})  : $signed({rng[31], rng[31:0]});
        hi33 = rng_uns ? $signed({1'b0, rng[63:32]}) : $signed({rng[63], rng[63:32]});
    end

    logic signed [65:0] sum;
    logic signed [65:0] shp;

    always_comb begin
        n_st     = r_st;
        n_slot   = r_slot;
        n_sub    = r_sub;
        n_dt     = r_dt;
        n_any    = r_any;
        n_pdata  = r_pdata;
        n_a      = r_a;
        n_life_v = r_life_v;
        n_sz_v   = r_sz_v;
        n_prod   = r_prod;
        n_okind  = r_okind;
        n_olast  = r_olast;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_active = r_active;
        n_we     = 1'b0;
        n_lfsr   = r_lfsr;
        mul_a    = '0;
        mul_b    = '0;
        sum      = '0;
        shp      = r_prod >>> FRAC_BITS;
        s_axis_tready = 1'b0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_st)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_dt  = s_axis_tdata;
                    n_sub = '0;
                    n_any = 1'b0;
                    if (s_axis_tuser == CMD_EMIT) begin
                        n_st = ST_FIND;
                    end else begin
                        n_slot = '0;
                        n_st   = ST_RD;
                    end
                end
            end
            ST_FIND: begin
                if (!free_ok) begin
                    n_okind = KIND_FULL;
                    n_odata = '0;
                    n_olast = 1'b1;
                    n_st    = ST_EMIT_OUT;
                end else begin
                    n_slot = free_idx;
                    n_a[0] = r_spawn[31:0];
                    n_a[1] = r_spawn[63:32];
                    n_st   = ST_DRAW;
                end
            end
            ST_DRAW: begin
                // Step LFSR, multiply r by (hi - lo).
                n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
                mul_a  = 33'(hi33 - lo33);
                mul_b  = $signed({17'd0, n_lfsr[15:0]});
                n_prod = mul_p;
                n_st   = ST_DRAW_WB;
            end
            ST_DRAW_WB: begin
                sum = 66'(lo33) + (r_prod >>> 16);
                case (r_sub)
                    2'd0:    n_life_v = sat32(sum);
                    2'd1:    n_sz_v   = sum[31:0];
                    2'd2:    n_a[2]   = sat32(sum);
                    default: n_a[3]   = sat32(sum);
                endcase
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    n_we    = 1'b1;
                    n_active[r_slot] = 1'b1;
                    n_okind = KIND_EMIT;
                    n_olast = 1'b1;
                    n_odata = {2'b00, r_sz_v, r_a[1], r_a[0], 6'(r_slot)};
                    n_st    = ST_EMIT_OUT;
                end else begin
                    n_st = ST_DRAW;
                end
            end
            ST_EMIT_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_st     = ST_WAIT;
                end
            end
            ST_RD: begin
                if (r_active[r_slot]) begin
                    n_st = ST_LIFE;
                end else begin
                    n_st = ST_NEXT;
                end
            end
            ST_LIFE: begin
                n_a[0]   = q_px;
                n_a[1]   = q_py;
                n_a[2]   = q_vx;
                n_a[3]   = q_vy;
                n_sz_v   = q_sz;
                n_life_v = sat32(66'($signed(q_lf)) - 66'($signed({1'b0, r_dt})));
                n_sub    = '0;
                if (n_life_v <= 0) begin
                    n_active[r_slot] = 1'b0;
                    n_we = 1'b1;
                    n_st = ST_NEXT;
                end else begin
                    n_st = ST_VEL;
                end
            end
            ST_VEL: begin
                mul_a  = r_sub[0] ? $signed({r_grav[63], r_grav[63:32]})
                                  : $signed({r_grav[31], r_grav[31:0]});
                mul_b  = $signed({1'b0, r_dt});
                n_prod = mul_p;
                n_st   = ST_VEL_WB;
            end
            ST_VEL_WB: begin
                sum = 66'(r_a[2 + r_sub[0]]) + shp;
                n_a[2 + r_sub[0]] = sat32(sum);
                n_sub = r_sub + 2'd1;
                n_st  = r_sub[0] ? ST_POS : ST_VEL;
                if (r_sub[0]) n_sub = '0;
            end
            ST_POS: begin
                mul_a  = 33'(r_a[2 + r_sub[0]]);
                mul_b  = $signed({1'b0, r_dt});
                n_prod = mul_p;
                n_st   = ST_POS_WB;
            end
            ST_POS_WB: begin
                sum = 66'(r_a[r_sub[0]]) + shp;
                n_a[r_sub[0]] = sat32(sum);
                n_sub = r_sub + 2'd1;
                if (r_sub[0]) begin
                    n_we = 1'b1;
                    n_st = ST_TICK_OUT;
                end else begin
                    n_st = ST_POS;
                end
            end
            ST_TICK_OUT: begin
                // The survivor is held until the next one turns up, so the word
                // released here is known not to be the final one.
                if (!r_any) begin
                    n_pdata = {2'b00, r_sz_v, r_a[1], r_a[0], 6'(r_slot)};
                    n_any   = 1'b1;
                    n_st    = ST_NEXT;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_PART;
                    n_olast  = 1'b0;
                    n_odata  = r_pdata;
                    n_pdata  = {2'b00, r_sz_v, r_a[1], r_a[0], 6'(r_slot)};
                    n_st     = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (32'(r_slot) == POOL_SIZE - 1) begin
                    // The held survivor goes out as the final word, or the empty
                    // report when no particle is left.
                    if (!r_ovalid || m_axis_tready) begin
                        n_ovalid = 1'b1;
                        n_olast  = 1'b1;
                        if (r_any) begin
                            n_okind = KIND_PART;
                            n_odata = r_pdata;
                        end else begin
                            n_okind = KIND_EMPTY;
                            n_odata = '0;
                        end
                        n_any = 1'b0;
                        n_st  = ST_WAIT;
                    end
                end else begin
                    n_slot = r_slot + SW'(1);
                    n_st   = ST_RD;
                end
            end
            ST_WAIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
        if (i_cfg_we && i_cfg_idx == REG_SEED) begin
            n_lfsr = (i_cfg_data[31:0] == 32'd0) ? 32'd1 : i_cfg_data[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_active <= '0;
            r_ovalid <= 1'b0;
            r_lfsr   <= 32'd1;
            r_spawn  <= '0;
            r_life   <= '0;
            r_size   <= '0;
            r_vx     <= '0;
            r_vy     <= '0;
            r_grav   <= '0;
            r_we     <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
            r_lfsr   <= n_lfsr;
            r_we     <= n_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SPAWN: r_spawn <= i_cfg_data;
                    REG_LIFE:  r_life  <= i_cfg_data;
                    REG_SIZE:  r_size  <= i_cfg_data;
                    REG_VX:    r_vx    <= i_cfg_data;
                    REG_VY:    r_vy    <= i_cfg_data;
                    REG_GRAV:  r_grav  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_sub    <= n_sub;
        r_dt     <= n_dt;
        r_any    <= n_any;
        r_pdata  <= n_pdata;
        r_a      <= n_a;
        r_life_v <= n_life_v;
        r_sz_v   <= n_sz_v;
        r_prod   <= n_prod;
        r_okind  <= n_okind;
        r_olast  <= n_olast;
        r_odata  <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_emit_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DRAW_WB && r_sub == 2'd3) |=> r_active[$past(r_slot)])
        else $error("emitted slot not active");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_IDLE) |-> !r_we) else $error("memory write while idle");
endmodule

@@ test/particle_pool_integrator_core_test.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for the particle pool integrator.
// A behavioral copy of the pool predicts every result word as commands are
// accepted. A separate process compares each taken result word, field by field,
// with the oldest prediction. The sender works in bursts with gaps, and the
// receiver stalls on a pattern of its own, with one long hold-off as well.
module particle_pool_integrator_core_test;
    import ppi_pkg::*;

    localparam int NSLOT = 64;
    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] sz;
        logic        last;
    } t_particle_word;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // delta_time
    logic         s_axis_tuser;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // slot[5:0], pos_x, pos_y, size, zero fill
    logic [1:0]   m_axis_tuser;   // kind
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0] i_cfg_data;

    particle_pool_integrator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the block's configuration and pool.
    logic [63:0] spawn_reg, life_reg, size_reg, vx_reg, vy_reg, grav_reg;
    logic [31:0] lfsr;
    logic [NSLOT-1:0] alive;
    logic signed [31:0] pos_x_m [NSLOT];
    logic signed [31:0] pos_y_m [NSLOT];
    logic signed [31:0] vel_x_m [NSLOT];
    logic signed [31:0] vel_y_m [NSLOT];
    logic signed [31:0] life_m  [NSLOT];
    logic [31:0]        size_m  [NSLOT];

    t_particle_word pending_words[$];
    int  errors = 0;
    bit  hold_off = 0;
    longint cycles = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -68'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Arithmetic shift right floors, which is what the block does.
    function automatic logic signed [67:0] scaled(input logic signed [67:0] a,
                                                  input logic signed [67:0] b);
        logic signed [67:0] p;
        p = a * b;
        return p >>> FB;
    endfunction

    function automatic logic signed [67:0] draw_value(input logic signed [67:0] lo,
                                                      input logic signed [67:0] hi);
        logic out_bit;
        logic signed [67:0] r;
        out_bit = lfsr[0];
        lfsr = lfsr >> 1;
        if (out_bit) lfsr = lfsr ^ LFSR_TAPS;
        r = {52'd0, lfsr[15:0]};
        return lo + ((r * (hi - lo)) >>> 16);
    endfunction

    function automatic logic signed [67:0] sx(input logic [31:0] v);
        return {{36{v[31]}}, v};
    endfunction

    function automatic logic signed [67:0] zx(input logic [31:0] v);
        return {36'd0, v};
    endfunction

    task automatic push_word(input logic [1:0] k, input int s, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z, input logic l);
        t_particle_word w;
        w.kind = k; w.slot = s[5:0]; w.px = x; w.py = y; w.sz = z; w.last = l;
        pending_words.push_back(w);
    endtask

    // Work out the result words of one accepted command.
    task automatic predict_pool(input logic cmd, input logic [31:0] dt);
        logic signed [67:0] d;
        int n;
        int hit;
        d = zx(dt);
        if (cmd == CMD_EMIT) begin
            hit = -1;
            for (int i = 0; i < NSLOT; i++)
                if (hit < 0 && !alive[i]) hit = i;
            if (hit < 0) begin
                push_word(KIND_FULL, 0, 32'd0, 32'd0, 32'd0, 1'b1);
            end else begin
                pos_x_m[hit] = spawn_reg[31:0];
                pos_y_m[hit] = spawn_reg[63:32];
                life_m[hit]  = clamp32(draw_value(sx(life_reg[31:0]), sx(life_reg[63:32])));
                size_m[hit]  = 32'(draw_value(zx(size_reg[31:0]), zx(size_reg[63:32])));
                vel_x_m[hit] = clamp32(draw_value(sx(vx_reg[31:0]), sx(vx_reg[63:32])));
                vel_y_m[hit] = clamp32(draw_value(sx(vy_reg[31:0]), sx(vy_reg[63:32])));
                alive[hit] = 1'b1;
                push_word(KIND_EMIT, hit, pos_x_m[hit], pos_y_m[hit], size_m[hit], 1'b1);
            end
        end else begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!alive[i]) continue;
                life_m[i] = clamp32(sx(life_m[i]) - d);
                if (life_m[i] <= 0) begin
                    alive[i] = 1'b0;
                    continue;
                end
                vel_x_m[i] = clamp32(sx(vel_x_m[i]) + scaled(sx(grav_reg[31:0]), d));
                vel_y_m[i] = clamp32(sx(vel_y_m[i]) + scaled(sx(grav_reg[63:32]), d));
                pos_x_m[i] = clamp32(sx(pos_x_m[i]) + scaled(sx(vel_x_m[i]), d));
                pos_y_m[i] = clamp32(sx(pos_y_m[i]) + scaled(sx(vel_y_m[i]), d));
                push_word(KIND_PART, i, pos_x_m[i], pos_y_m[i], size_m[i], 1'b0);
                n++;
            end
            if (n == 0) push_word(KIND_EMPTY, 0, 32'd0, 32'd0, 32'd0, 1'b1);
            else pending_words[$].last = 1'b1;
        end
    endtask

    // Receiver: random stall pattern, plus the long hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (cycles % 512 < 128) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_particle_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                w = pending_words.pop_front();
                if (m_axis_tuser !== w.kind) begin
                    $error("kind: expected %0d, got %0d", w.kind, m_axis_tuser); errors++;
                end
                if (m_axis_tdata[5:0] !== w.slot) begin
                    $error("slot: expected %0d, got %0d", w.slot, m_axis_tdata[5:0]);
                    errors++;
                end
                if (m_axis_tdata[37:6] !== w.px) begin
                    $error("pos_x: expected %h, got %h", w.px, m_axis_tdata[37:6]); errors++;
                end
                if (m_axis_tdata[69:38] !== w.py) begin
                    $error("pos_y: expected %h, got %h", w.py, m_axis_tdata[69:38]); errors++;
                end
                if (m_axis_tdata[101:70] !== w.sz) begin
                    $error("particle_size: expected %h, got %h", w.sz, m_axis_tdata[101:70]);
                    errors++;
                end
                if (m_axis_tlast !== w.last) begin
                    $error("last: expected %0d, got %0d", w.last, m_axis_tlast); errors++;
                end
            end
        end
    end

    // Send one command word; prediction happens at the accepting edge. The
    // inputs are set at the falling edge, so back-to-back calls hand over cleanly.
    task automatic send_command(input logic cmd, input logic [31:0] dt);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = dt;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pool(cmd, dt);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Random gap after a burst of random length.
    int burst_left = 0;
    task automatic pace_sender;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_SPAWN: spawn_reg = val;
            REG_LIFE:  life_reg  = val;
            REG_SIZE:  size_reg  = val;
            REG_VX:    vx_reg    = val;
            REG_VY:    vy_reg    = val;
            REG_GRAV:  grav_reg  = val;
            REG_SEED:  lfsr = (val[31:0] == 0) ? 32'd1 : val[31:0];
            default: ;
        endcase
    endtask

    // Configuration changes only once every pending word has come out.
    task automatic drain;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Retire every particle so that later phases start from an empty pool.
    task automatic clear_pool;
        send_command(CMD_TICK, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_directed;
        // Reset defaults: zero ranges give zero lifetime, retired at the next tick.
        send_command(CMD_TICK, 32'h0001_0000);
        send_command(CMD_EMIT, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'd0);
        drain();
        write_reg(REG_SPAWN, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_LIFE,  {32'h7FFF_FFFF, 32'h0010_0000});
        write_reg(REG_SIZE,  {32'hFFFF_FFFF, 32'd0});
        write_reg(REG_VX,    {32'h8000_0000, 32'h7FFF_FFFF});   // max below min
        write_reg(REG_VY,    {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_GRAV,  {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_SEED,  64'd0);                            // zero seed becomes one
        write_reg(3'd7,      64'hDEAD_BEEF_DEAD_BEEF);          // unused index
        repeat (4) send_command(CMD_EMIT, 32'd0);
        send_command(CMD_TICK, 32'd0);
        send_command(CMD_TICK, 32'h0000_0001);
        send_command(CMD_TICK, 32'h0004_0000);                  // drives saturation
        drain();
        // Negative lifetimes retire at the first tick.
        write_reg(REG_LIFE, {32'hFFFF_0000, 32'h8000_0000});
        send_command(CMD_EMIT, 32'd0);
        send_command(CMD_TICK, 32'd1);
        drain();
        clear_pool();
    endtask

    task automatic test_pool_full;
        write_reg(REG_LIFE, {32'h7FFF_FFFF, 32'h7000_0000});
        write_reg(REG_SEED, 64'h0000_0000_FFFF_FFFF);
        for (int i = 0; i < NSLOT + 2; i++) send_command(CMD_EMIT, $urandom);
        send_command(CMD_TICK, 32'h0000_0100);
        drain();
        clear_pool();
    endtask

    task automatic test_backpressure;
        // The receiver holds off while the sender keeps offering commands.
        hold_off = 1;
        fork
            begin
                repeat (2000) @(negedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++)
                send_command(i % 3 == 2 ? CMD_TICK : CMD_EMIT, 32'h0000_0800);
        join
        drain();
        clear_pool();
    endtask

    task automatic random_range(input logic [IDX_W-1:0] idx);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 1)) v = v & 64'h001F_FFFF_001F_FFFF;
        if ($urandom_range(0, 1)) v = v | 64'hFFE0_0000_FFE0_0000;
        write_reg(idx, v);
    endtask

    task automatic test_random;
        logic [31:0] dt;
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = REG_SPAWN; r <= REG_GRAV; r++) random_range(r[IDX_W-1:0]);
            write_reg(REG_LIFE, {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF)) | 31'h0010_0000,
                                 1'b0, 31'($urandom_range(0, 32'h00FF_FFFF))});
            write_reg(REG_SEED, {32'd0, $urandom});
            for (int i = 0; i < 28; i++) begin
                pace_sender();
                case ($urandom_range(0, 9))
                    0:       dt = $urandom;
                    1, 2:    dt = $urandom_range(0, 16);
                    default: dt = $urandom_range(0, 32'h0000_4000);
                endcase
                send_command($urandom_range(0, 2) == 0 ? CMD_TICK : CMD_EMIT, dt);
            end
            drain();
            clear_pool();
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        m_axis_tready = 0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        spawn_reg = 0; life_reg = 0; size_reg = 0; vx_reg = 0; vy_reg = 0; grav_reg = 0;
        lfsr = 32'd1;
        alive = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random();
        drain();
        repeat (600) @(negedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
